// ===== design/xcwc_pkg.sv =====
// package: types and constants for the chained-xor word cipher
`default_nettype none
package xcwc_pkg;

  localparam int unsigned KeyWidth   = 32;
  localparam int unsigned QueueDepth = 8;
  localparam int unsigned CountWidth = $clog2(QueueDepth + 1);

  localparam logic [7:0] BypassByte1  = 8'h01;
  localparam logic [7:0] BypassFirstA = 8'h02;
  localparam logic [7:0] BypassFirstB = 8'h1d;

  localparam logic CFG_CHAIN_KEY = 1'b0;
  localparam logic CFG_DIRECTION = 1'b1;

  typedef enum logic [1:0] {
    POS_BYTE0 = 2'd0,
    POS_BYTE1 = 2'd1,
    POS_BODY  = 2'd2
  } pos_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_t;

endpackage
`default_nettype wire

// ===== design/xor_chain_word_cipher.sv =====
// top level: chained-xor word cipher over a byte stream with output queue
//
// Bytes of a packet enter on the in_ channel (valid/ready), last marks the
// final byte. Processed bytes leave on the out_ channel in packet order.
// Each accepted request is handled at once: any results are pushed into an
// eight-entry output queue at the edge that accepts the byte, so with an
// empty queue the first result is visible in the next cycle. A completed
// body word pushes four bytes at once; the queue drains one byte per cycle
// while out_ready is high. in_ready is high while the queue has room for
// four more entries, so a new byte can be taken every cycle and, at one
// byte in per byte out, the sustained rate is one byte per cycle. When the
// receiver stalls, the queue fills and in_ready drops until entries are
// taken. cfg_we writes chain_key (index 0) or direction (index 1).
// Synchronous reset empties the queue, clears the key, direction and control
// registers and returns the block to the start of a packet.
`default_nettype none
module xor_chain_word_cipher
  import xcwc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire in_t                 in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output out_t                     out_data,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [KeyWidth-1:0] cfg_wdata
);

  logic [KeyWidth-1:0] chain_key_r;
  logic                direction_r;

  pos_t                pos_r, pos_nxt;
  logic [7:0]          first_r, first_nxt;
  logic                bypass_r, bypass_nxt;
  logic [KeyWidth-1:0] key_r, key_nxt;
  logic [23:0]         pend_r, pend_nxt;
  logic [1:0]          pcnt_r, pcnt_nxt;

  out_t                queue_r [QueueDepth];
  out_t                queue_nxt [QueueDepth];
  logic [CountWidth-1:0] count_r, count_nxt;

  logic                accept;
  logic                pop;
  logic [7:0]          b;
  logic                lst;
  logic [2:0]          n_res;
  out_t                res [4];
  logic [31:0]         word;
  logic [31:0]         xword;
  logic [2:0]          cnt1;
  logic [CountWidth-1:0] base;

  assign in_ready  = (count_r <= CountWidth'(QueueDepth - 4));
  assign accept    = in_valid && in_ready;
  assign out_valid = (count_r != '0);
  assign out_data  = queue_r[0];
  assign pop       = out_valid && out_ready;
  assign b         = in_data.data_byte;
  assign lst       = in_data.last;
  assign word      = {b, pend_r};
  assign xword     = word ^ key_r;
  assign cnt1      = {1'b0, pcnt_r} + 3'd1;

  // packet position
  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      case (pos_r)
        POS_BYTE0: pos_nxt = lst ? POS_BYTE0 : POS_BYTE1;
        POS_BYTE1: pos_nxt = lst ? POS_BYTE0 : POS_BODY;
        POS_BODY:  pos_nxt = lst ? POS_BYTE0 : POS_BODY;
        default:   pos_nxt = POS_BYTE0;
      endcase
    end
  end

  // per-byte datapath and results
  always_comb begin
    first_nxt  = first_r;
    bypass_nxt = bypass_r;
    key_nxt    = key_r;
    pend_nxt   = pend_r;
    pcnt_nxt   = pcnt_r;
    n_res      = 3'd0;
    for (int k = 0; k < 4; k++) begin
      res[k] = '{out_byte: b, out_last: 1'b0};
    end
    if (accept) begin
      case (pos_r)
        POS_BYTE0: begin
          first_nxt = b;
          key_nxt   = chain_key_r;
          pcnt_nxt  = 2'd0;
          n_res     = 3'd1;
          res[0]    = '{out_byte: b, out_last: lst};
        end
        POS_BYTE1: begin
          bypass_nxt = (b == BypassByte1) || (first_r == BypassFirstA) ||
                       (first_r == BypassFirstB);
          pcnt_nxt   = 2'd0;
          n_res      = 3'd1;
          res[0]     = '{out_byte: b, out_last: lst};
        end
        POS_BODY: begin
          if (bypass_r) begin
            n_res  = 3'd1;
            res[0] = '{out_byte: b, out_last: lst};
            if (lst) pcnt_nxt = 2'd0;
          end else if (pcnt_r == 2'd3) begin
            key_nxt  = direction_r ? xword : word;
            pcnt_nxt = 2'd0;
            n_res    = 3'd4;
            for (int k = 0; k < 4; k++) begin
              res[k] = '{out_byte: xword[8*k +: 8], out_last: lst && (k == 3)};
            end
          end else begin
            case (pcnt_r)
              2'd0:    pend_nxt = {16'h0000, b};
              2'd1:    pend_nxt = {8'h00, b, pend_r[7:0]};
              default: pend_nxt = {b, pend_r[15:0]};
            endcase
            if (lst) begin
              pcnt_nxt = 2'd0;
              n_res    = cnt1;
              for (int k = 0; k < 3; k++) begin
                res[k] = '{out_byte: pend_nxt[8*k +: 8] ^ key_r[7:0],
                           out_last: (3'(k) + 3'd1 == cnt1)};
              end
            end else begin
              pcnt_nxt = cnt1[1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // output queue: shift on pop, append results behind the held entries
  always_comb begin
    base = count_r - CountWidth'(pop);
    for (int i = 0; i < QueueDepth; i++) begin
      if (pop && (i < QueueDepth - 1)) begin
        queue_nxt[i] = queue_r[(i + 1) % QueueDepth];
      end else begin
        queue_nxt[i] = queue_r[i];
      end
      for (int k = 0; k < 4; k++) begin
        if ((3'(k) < n_res) && (base + CountWidth'(k) == CountWidth'(i))) begin
          queue_nxt[i] = res[k];
        end
      end
    end
    count_nxt = base + CountWidth'(n_res);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_key_r <= '0;
      direction_r <= 1'b0;
      pos_r       <= POS_BYTE0;
      first_r     <= '0;
      bypass_r    <= 1'b0;
      key_r       <= '0;
      pcnt_r      <= '0;
      count_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHAIN_KEY: chain_key_r <= cfg_wdata;
          CFG_DIRECTION: direction_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      pos_r    <= pos_nxt;
      first_r  <= first_nxt;
      bypass_r <= bypass_nxt;
      key_r    <= key_nxt;
      pcnt_r   <= pcnt_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    for (int i = 0; i < QueueDepth; i++) begin
      queue_r[i] <= queue_nxt[i];
    end
  end

endmodule
`default_nettype wire

// ===== test/xcwc_cipher_check.sv =====
// checker for the chained-xor word cipher: predicts result bytes and compares them
`timescale 1ns / 1ps
module xcwc_cipher_check
  import xcwc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_t                 in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_t                out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [KeyWidth-1:0] cfg_wdata,
  output int                  mismatches,
  output int                  outstanding,
  output int                  bytes_checked
);

  logic [KeyWidth-1:0] chain_key;
  logic                direction;
  pos_t                position;
  logic [7:0]          first_byte;
  logic                bypass;
  logic [KeyWidth-1:0] running_key;
  logic [23:0]         held_bytes;
  logic [1:0]          held_count;

  out_t expected_bytes[$];
  out_t want;

  function automatic void push_result(input logic [7:0] b, input logic l);
    out_t r;
    r.out_byte = b;
    r.out_last = l;
    expected_bytes.push_back(r);
  endfunction

  task automatic cipher_request(input in_t req);
    logic [31:0] word;
    logic [31:0] res;
    int n;
    case (position)
      POS_BYTE0: begin
        first_byte = req.data_byte;
        running_key = chain_key;
        held_count = '0;
        push_result(req.data_byte, req.last);
        position = req.last ? POS_BYTE0 : POS_BYTE1;
      end
      POS_BYTE1: begin
        bypass = (req.data_byte == BypassByte1) || (first_byte == BypassFirstA) ||
                 (first_byte == BypassFirstB);
        push_result(req.data_byte, req.last);
        position = req.last ? POS_BYTE0 : POS_BODY;
        held_count = '0;
      end
      default: begin
        if (bypass) begin
          push_result(req.data_byte, req.last);
        end else if (held_count == 2'd3) begin
          word = {req.data_byte, held_bytes};
          res = word ^ running_key;
          running_key = direction ? res : word;
          for (int k = 0; k < 4; k++) begin
            push_result(res[8*k +: 8], req.last && k == 3);
          end
          held_count = '0;
        end else begin
          held_bytes[8*held_count +: 8] = req.data_byte;
          held_count = held_count + 2'd1;
          if (req.last) begin
            // tail bytes only see the low byte of the key
            n = held_count;
            for (int k = 0; k < n; k++) begin
              push_result(held_bytes[8*k +: 8] ^ running_key[7:0], k == n - 1);
            end
            held_count = '0;
          end
        end
        if (req.last) begin
          position = POS_BYTE0;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      chain_key = '0;
      direction = 1'b0;
      position = POS_BYTE0;
      first_byte = '0;
      bypass = 1'b0;
      running_key = '0;
      held_bytes = '0;
      held_count = '0;
      expected_bytes.delete();
      mismatches = 0;
      bytes_checked = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_CHAIN_KEY) begin
          chain_key = cfg_wdata;
        end else begin
          direction = cfg_wdata[0];
        end
      end
      if (in_valid && in_ready) begin
        cipher_request(in_data);
      end
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected result byte %h last %b", $time,
                   out_data.out_byte, out_data.out_last);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (out_data.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %h got %h", $time,
                     want.out_byte, out_data.out_byte);
            mismatches++;
          end
          if (out_data.out_last !== want.out_last) begin
            $display("%0t: out_last expected %b got %b", $time,
                     want.out_last, out_data.out_last);
            mismatches++;
          end
        end
      end
      outstanding <= expected_bytes.size();
    end
  end

endmodule

// ===== test/xor_chain_word_cipher_tb.sv =====
// testbench top for the chained-xor word cipher: stimulus, settings and verdict
`timescale 1ns / 1ps
module xor_chain_word_cipher_tb;
  import xcwc_pkg::*;

  localparam int MaxCycles   = 200000;
  localparam int DrainCycles = 6;
  localparam int Phases      = 9;
  localparam int PhaseItems  = 20;
  localparam int PressurePhase = 3;
  localparam int HoldCycles  = 80;
  localparam int DirectedLen = 24;

  localparam logic [7:0] DirectedBytes [DirectedLen] = '{
    8'h00,
    8'hff, 8'h00,
    8'h02, 8'h7e, 8'hff,
    8'h1d, 8'h80, 8'h00,
    8'h40, 8'h01, 8'h5a,
    8'h00, 8'hff, 8'h11, 8'h22, 8'h33, 8'h44, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'ha5
  };
  localparam logic [DirectedLen-1:0] DirectedLast =
    (24'd1 << 0) | (24'd1 << 2) | (24'd1 << 5) | (24'd1 << 8) | (24'd1 << 11) | (24'd1 << 23);

  typedef enum int {
    PKT_NORMAL,
    PKT_SHORT,
    PKT_BYPASS_BYTE1,
    PKT_BYPASS_FIRST_A,
    PKT_BYPASS_FIRST_B
  } pkt_kind_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_t                 in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;
  logic                cfg_we = 1'b0;
  logic                cfg_index = CFG_CHAIN_KEY;
  logic [KeyWidth-1:0] cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int bytes_checked;

  int requests_sent = 0;
  int packets_sent = 0;
  int settings_used = 0;
  int hold_off_request = 0;
  bit in_steady = 1'b0;
  bit out_steady = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  xor_chain_word_cipher dut (.*);

  xcwc_cipher_check cipher_check (.*);

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = in_steady ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, last: l};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_cipher(input logic [KeyWidth-1:0] key, input logic dir);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CHAIN_KEY;
    cfg_wdata <= key;
    @(posedge clk);
    cfg_index <= CFG_DIRECTION;
    cfg_wdata <= {{(KeyWidth-1){1'b0}}, dir};
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_packet(input pkt_kind_t kind, input int len, input int split_at);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if (split_at > 0 && i == split_at) begin
        // new key waits for the next packet, direction applies at the next word
        wait_idle();
        set_cipher($urandom, 1'($urandom_range(0, 1)));
      end
      b = 8'($urandom_range(0, 255));
      if (i == 0) begin
        case (kind)
          PKT_BYPASS_FIRST_A: b = BypassFirstA;
          PKT_BYPASS_FIRST_B: b = BypassFirstB;
          default: begin
            if (b == BypassFirstA || b == BypassFirstB) b ^= 8'h80;
          end
        endcase
      end else if (i == 1) begin
        if (kind == PKT_BYPASS_BYTE1) begin
          b = BypassByte1;
        end else if (b == BypassByte1) begin
          b = 8'h81;
        end
      end
      send_byte(b, i == len - 1);
    end
    packets_sent++;
  endtask

  // receiver side
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_request > 0) begin
        hold_left = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!out_steady) stall_left = idle_gap();
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < MaxCycles) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still expected", cycles, outstanding);
    $display("** xor_chain_word_cipher: FAILED **");
    $finish;
  end

  initial begin
    int phase_start;
    int r;
    int len;
    pkt_kind_t kind;
    logic [KeyWidth-1:0] key;
    logic dir;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short packets, each bypass trigger, then two chained words and a tail
    set_cipher(32'hffff_ffff, 1'b1);
    for (int i = 0; i < DirectedLen; i++) begin
      send_byte(DirectedBytes[i], DirectedLast[i]);
      if (DirectedLast[i]) packets_sent++;
    end
    wait_idle();

    for (int phase = 0; phase < Phases; phase++) begin
      case (phase % 4)
        0: key = '0;
        1: key = '1;
        default: key = $urandom;
      endcase
      dir = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
      set_cipher(key, dir);
      in_steady = ($urandom_range(0, 3) == 0);
      out_steady = ($urandom_range(0, 3) == 0);
      phase_start = requests_sent;

      if (phase == PressurePhase) begin
        in_steady = 1'b1;
        hold_off_request = HoldCycles;
        send_packet(PKT_NORMAL, 40, 0);
        in_steady = 1'b0;
      end
      if (phase % 3 == 2) begin
        send_packet(PKT_NORMAL, $urandom_range(10, 16), $urandom_range(3, 9));
      end

      while (requests_sent - phase_start < PhaseItems) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          kind = PKT_SHORT;
          len = $urandom_range(1, 2);
        end else if (r < 22) begin
          kind = pkt_kind_t'(PKT_BYPASS_BYTE1 + $urandom_range(0, 2));
          len = $urandom_range(3, 10);
        end else begin
          kind = PKT_NORMAL;
          len = (r < 90) ? $urandom_range(3, 14) : $urandom_range(15, 26);
        end
        send_packet(kind, len, 0);
      end
      wait_idle();
    end

    $display("run covered %0d requests in %0d packets under %0d key/direction settings",
             requests_sent, packets_sent, settings_used);
    $display("%0d result bytes compared, output held off for %0d cycles once",
             bytes_checked, HoldCycles);
    if (mismatches == 0) begin
      $display("** xor_chain_word_cipher: PASSED **");
    end else begin
      $display("** xor_chain_word_cipher: FAILED **");
    end
    $finish;
  end

endmodule
